// File: rtl/dbvc_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// dependency bit-vector clock block. No dependencies.
package dbvc_pkg;

    localparam int MAX_CLOCKS = 16;
    localparam int MAX_DIMS   = 16;
    localparam int CLK_W      = $clog2(MAX_CLOCKS);
    localparam int DIM_W      = $clog2(MAX_DIMS);
    localparam int CNT_W      = $clog2(MAX_CLOCKS + 1);
    localparam int LEN_W      = $clog2(MAX_DIMS + 1);

    localparam int IN_W  = 16;
    localparam int OUT_W = 32;

    localparam logic [2:0] KIND_CREATE   = 3'd0;
    localparam logic [2:0] KIND_JOIN     = 3'd1;
    localparam logic [2:0] KIND_SNAPSHOT = 3'd2;
    localparam logic [2:0] KIND_TEST     = 3'd3;
    localparam logic [2:0] KIND_CLEAR    = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_DIM_BAD = 2'd1;
    localparam logic [1:0] STAT_UNKNOWN = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;   // take the input beat
        logic step;     // one closure step
        logic emit;     // load snapshot/test result into output register
    } cmd_t;

    typedef struct packed {
        logic needs_close;  // input beat is a snapshot/test on a known clock
        logic closed;       // frontier stopped growing
        logic out_free;     // output register can take a result this cycle
    } sts_t;

endpackage

// File: rtl/dependency_bit_vector_clock_top.sv
// Top level of the dependency bit-vector clock block.
// Depends on dbvc_pkg, dbvc_ctrl and dbvc_dp.
//
//  channel   ports               beat contents
//  -------   -----------------   -----------------------------------------------
//  input     s_tvalid/tready     s_tdata: kind, dimension, target_clock, source_clock
//  output    m_tvalid/tready     m_tdata: status, new_clock, clock_bits,
//                                         bit_value, vector_length
//
// Create, join, clear, spare-kind and unknown-clock beats are written to the
// output register when accepted. Snapshot and test walk the dependency closure
// one frontier step per cycle, then wait in ST_EMIT until the output register
// is free to take the result.
// rst_n clears the tables, the FSM and the output valid.
// A stalled output holds the next beat off at the input; the next beat is
// taken in the cycle the waiting result leaves.
module dependency_bit_vector_clock_top
    import dbvc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // [2:0] kind, [6:3] dimension, [10:7] target_clock, [14:11] source_clock,
    // [15] zero
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [1:0] status, [5:2] new_clock, [21:6] clock_bits, [22] bit_value,
    // [27:23] vector_length, [31:28] zero
    output logic [OUT_W-1:0]  m_tdata
);

    cmd_t cmd;
    sts_t sts;

    dbvc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dbvc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// File: rtl/dbvc_ctrl.sv
// Controller FSM: sequences accept, closure iteration and result emit.
// Depends on dbvc_pkg.
module dbvc_ctrl
    import dbvc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && sts.out_free && sts.needs_close)
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                if (sts.closed)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.step   = 1'b0;
        cmd.emit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = sts.out_free;
                cmd.accept = in_valid && sts.out_free;
            end
            ST_CLOSE:
            begin
                cmd.step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/dbvc_dp.sv
// Datapath: clock tables, dependency matrix, closure frontier and output
// register. Depends on dbvc_pkg; driven by dbvc_ctrl commands.
module dbvc_dp
    import dbvc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IN_W-1:0]   in_data,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [OUT_W-1:0]  out_data
);

    // clock tables
    logic [MAX_CLOCKS-1:0] dep_reg [MAX_CLOCKS];
    logic [MAX_CLOCKS-1:0] dep_next [MAX_CLOCKS];
    logic [DIM_W-1:0]      cdim_reg [MAX_CLOCKS];
    logic [MAX_DIMS-1:0]   owned_reg, owned_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [LEN_W-1:0]      len_reg, len_next;

    // item and closure
    logic [DIM_W-1:0]      dim_reg;
    logic [2:0]            kind_reg;
    logic [MAX_CLOCKS-1:0] visited_reg, visited_next;
    logic [MAX_CLOCKS-1:0] frontier;
    logic [MAX_DIMS-1:0]   snap_bits;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_data_reg, out_data_next;

    logic [2:0]            in_kind;
    logic [DIM_W-1:0]      in_dim;
    logic [CLK_W-1:0]      in_tgt;
    logic [CLK_W-1:0]      in_src;
    logic                  tgt_ok, src_ok, dim_bad, full;
    logic [1:0]            res_status;
    logic [CLK_W-1:0]      res_newc;
    logic                  cdim_we;
    logic                  out_free;

    assign in_kind = in_data[2:0];
    assign in_dim  = in_data[6:3];
    assign in_tgt  = in_data[10:7];
    assign in_src  = in_data[14:11];

    assign tgt_ok  = {1'b0, in_tgt} < count_reg;
    assign src_ok  = {1'b0, in_src} < count_reg;
    assign dim_bad = ({1'b0, in_dim} >= (DIM_W+1)'(MAX_DIMS)) || owned_reg[in_dim];
    assign full    = count_reg >= CNT_W'(MAX_CLOCKS);

    assign out_free = !out_valid_reg || out_ready;

    // one closure step: union of dependency rows of every visited clock
    always_comb
    begin
        frontier = visited_reg;
        for (int i = 0; i < MAX_CLOCKS; i++)
        begin
            if (visited_reg[i] && (CNT_W'(i) < count_reg))
            begin
                frontier = frontier | dep_reg[i];
            end
        end
    end

    always_comb
    begin
        snap_bits = '0;
        for (int i = 0; i < MAX_CLOCKS; i++)
        begin
            if (visited_reg[i] && (CNT_W'(i) < count_reg))
            begin
                snap_bits[cdim_reg[i]] = 1'b1;
            end
        end
    end

    assign sts.needs_close = ((in_kind == KIND_SNAPSHOT) || (in_kind == KIND_TEST)) && tgt_ok;
    assign sts.closed      = (frontier == visited_reg);
    assign sts.out_free    = out_free;

    // table updates and immediate results
    always_comb
    begin
        dep_next   = dep_reg;
        owned_next = owned_reg;
        count_next = count_reg;
        len_next   = len_reg;
        res_status = STAT_OK;
        res_newc   = '0;
        cdim_we    = 1'b0;
        if (cmd.accept)
        begin
            case (in_kind)
                KIND_CREATE:
                begin
                    if (dim_bad)
                    begin
                        res_status = STAT_DIM_BAD;
                    end
                    else if (full)
                    begin
                        res_status = STAT_FULL;
                    end
                    else
                    begin
                        cdim_we                       = 1'b1;
                        dep_next[count_reg[CLK_W-1:0]] = '0;
                        owned_next[in_dim]            = 1'b1;
                        if ({1'b0, in_dim} + 1'b1 > len_reg)
                        begin
                            len_next = {1'b0, in_dim} + 1'b1;
                        end
                        res_newc   = count_reg[CLK_W-1:0];
                        count_next = count_reg + 1'b1;
                    end
                end
                KIND_JOIN:
                begin
                    if (!tgt_ok || !src_ok)
                    begin
                        res_status = STAT_UNKNOWN;
                    end
                    else
                    begin
                        dep_next[in_tgt][in_src] = 1'b1;
                    end
                end
                KIND_SNAPSHOT, KIND_TEST:
                begin
                    if (!tgt_ok)
                    begin
                        res_status = STAT_UNKNOWN;
                    end
                end
                KIND_CLEAR:
                begin
                    for (int i = 0; i < MAX_CLOCKS; i++)
                    begin
                        dep_next[i] = '0;
                    end
                    owned_next = '0;
                    count_next = '0;
                    len_next   = '0;
                end
                default:
                begin
                    res_status = STAT_OK;
                end
            endcase
        end
    end

    // result register; pad bits stay zero
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        visited_next   = visited_reg;
        if (cmd.accept && sts.needs_close)
        begin
            visited_next = MAX_CLOCKS'(1) << in_tgt;
        end
        else if (cmd.accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {4'b0, len_next, 1'b0, 16'b0, res_newc, res_status};
        end
        else if (cmd.step)
        begin
            visited_next = frontier;
        end
        else if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {4'b0, len_reg,
                              (kind_reg == KIND_TEST) ? snap_bits[dim_reg] : 1'b0,
                              snap_bits, {CLK_W{1'b0}}, STAT_OK};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLOCKS; i++)
            begin
                dep_reg[i] <= '0;
            end
            owned_reg     <= '0;
            count_reg     <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dep_reg       <= dep_next;
            owned_reg     <= owned_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cdim_we)
        begin
            cdim_reg[count_reg[CLK_W-1:0]] <= in_dim;
        end
        if (cmd.accept)
        begin
            kind_reg <= in_kind;
            dim_reg  <= in_dim;
        end
        visited_reg  <= visited_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: test/dependency_bit_vector_clock_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for dependency_bit_vector_clock_top: directed and random
// create/join/snapshot/test/clear beats checked against an in-bench closure predictor.
// Depends on dbvc_pkg and the RTL of dependency_bit_vector_clock_top.
module dependency_bit_vector_clock_top_tb
    import dbvc_pkg::*;
();

    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    localparam int BEAT_TARGET  = 1700;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PRINTS   = 30;

    // packed so that status sits in the low bits, as on m_tdata
    typedef struct packed {
        logic [4:0]  vector_length;
        logic        bit_value;
        logic [15:0] clock_bits;
        logic [3:0]  new_clock;
        logic [1:0]  status;
    } clock_result_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    dependency_bit_vector_clock_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // stimulus and expected results
    logic [IN_W-1:0] pending_beats[$];
    clock_result_t   result_fifo[$];
    int              total_beats = 0;
    int              beats_in    = 0;
    int              results_out = 0;
    int              errors      = 0;
    int              kind_hits[8];
    int              status_hits[4];
    int              widest_reach = 0;
    int              hold_left    = 0;
    bit              hold_done    = 1'b0;
    int              quiet_cycles = 0;

    // predictor state
    logic [15:0] dep_mask[MAX_CLOCKS];
    logic [3:0]  dim_of[MAX_CLOCKS];
    logic [15:0] owned_mask = '0;
    logic [4:0]  clocks_made = '0;
    logic [4:0]  used_length = '0;

    // generator view of the system
    int          gen_count = 0;
    logic [15:0] gen_owned = '0;

    function automatic void wipe_clock_system();
        for (int i = 0; i < MAX_CLOCKS; i++)
        begin
            dep_mask[i] = '0;
            dim_of[i]   = '0;
        end
        owned_mask  = '0;
        clocks_made = '0;
        used_length = '0;
    endfunction

    function automatic clock_result_t predict_clock_op(logic [IN_W-1:0] beat);
        logic [2:0]    kind;
        logic [3:0]    dim;
        logic [3:0]    tgt;
        logic [3:0]    src;
        logic [15:0]   visited;
        logic [15:0]   next_set;
        int            reach;
        clock_result_t r;
        kind = beat[2:0];
        dim  = beat[6:3];
        tgt  = beat[10:7];
        src  = beat[14:11];
        r    = '0;
        kind_hits[kind]++;
        case (kind)
            KIND_CREATE:
            begin
                if (dim >= MAX_DIMS || owned_mask[dim])
                    r.status = STAT_DIM_BAD;
                else if (clocks_made >= MAX_CLOCKS)
                    r.status = STAT_FULL;
                else
                begin
                    dim_of[clocks_made]   = dim;
                    dep_mask[clocks_made] = '0;
                    owned_mask[dim]       = 1'b1;
                    if (dim + 5'd1 > used_length)
                        used_length = dim + 5'd1;
                    r.new_clock = clocks_made[3:0];
                    clocks_made++;
                end
            end
            KIND_JOIN:
            begin
                if (tgt >= clocks_made || src >= clocks_made)
                    r.status = STAT_UNKNOWN;
                else
                    dep_mask[tgt][src] = 1'b1;
            end
            KIND_SNAPSHOT, KIND_TEST:
            begin
                if (tgt >= clocks_made)
                    r.status = STAT_UNKNOWN;
                else
                begin
                    // grow the reachable set until it stops changing
                    visited = 16'b1 << tgt;
                    for (int step = 0; step < MAX_CLOCKS; step++)
                    begin
                        next_set = visited;
                        for (int i = 0; i < clocks_made; i++)
                            if (visited[i])
                                next_set |= dep_mask[i];
                        visited = next_set;
                    end
                    for (int i = 0; i < clocks_made; i++)
                        if (visited[i])
                            r.clock_bits[dim_of[i]] = 1'b1;
                    reach = $countones(visited);
                    if (reach > widest_reach)
                        widest_reach = reach;
                    if (kind == KIND_TEST)
                        r.bit_value = r.clock_bits[dim];
                end
            end
            KIND_CLEAR:
                wipe_clock_system();
            default:
                ;
        endcase
        r.vector_length = used_length;
        status_hits[r.status]++;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch at %0t ns, result %0d: %s got 0x%0h expected 0x%0h",
                     $time, results_out, what, got, want);
    endtask

    // 0: sender 38 / receiver 45, 1: swapped, 2: no idling
    function automatic int idle_phase();
        if (beats_in < total_beats / 3)
            return 0;
        else if (beats_in < 2 * total_beats / 3)
            return 1;
        return 2;
    endfunction

    function automatic bit roll_idle(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // ---------------------------------------------------------------- driver
    always @(posedge clk or negedge rst_n)
    begin : drive_beats
        int            ph;
        bit            rest;
        clock_result_t predicted;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predicted   = predict_clock_op(s_tdata);
                result_fifo = {result_fifo, predicted};
                beats_in <= beats_in + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                ph   = idle_phase();
                rest = (ph == 0) ? roll_idle(38) : (ph == 1) ? roll_idle(45) : 1'b0;
                if (pending_beats.size() > 0 && !rest)
                begin
                    s_tdata  <= pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge clk or negedge rst_n)
    begin : check_results
        clock_result_t got;
        clock_result_t want;
        int            ph;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(clock_result_t)-1:0];
                if (result_fifo.size() == 0)
                    report_mismatch("unexpected beat", m_tdata, 0);
                else
                begin
                    want = result_fifo.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.new_clock !== want.new_clock)
                        report_mismatch("new_clock", got.new_clock, want.new_clock);
                    if (got.clock_bits !== want.clock_bits)
                        report_mismatch("clock_bits", got.clock_bits, want.clock_bits);
                    if (got.bit_value !== want.bit_value)
                        report_mismatch("bit_value", got.bit_value, want.bit_value);
                    if (got.vector_length !== want.vector_length)
                        report_mismatch("vector_length", got.vector_length,
                                        want.vector_length);
                end
                results_out++;
            end
            // one long back-pressure stretch so the block fills and stalls its input
            if (!hold_done && beats_in >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            ph = idle_phase();
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= (ph == 0) ? !roll_idle(45) : (ph == 1) ? !roll_idle(38) : 1'b1;
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
                $display("dependency_bit_vector_clock_top test failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic add_beat(logic [2:0] kind, logic [3:0] dim, logic [3:0] tgt,
                            logic [3:0] src);
        logic [IN_W-1:0] beat;
        beat          = {1'b0, src, tgt, dim, kind};
        pending_beats = {pending_beats, beat};
    endtask

    function automatic logic [3:0] any4();
        return 4'($urandom_range(0, 15));
    endfunction

    // mostly a live clock, now and then any number
    function automatic logic [3:0] pick_clock();
        if (gen_count == 0 || $urandom_range(0, 9) == 0)
            return any4();
        return 4'($urandom_range(0, gen_count - 1));
    endfunction

    task automatic gen_create(logic [3:0] dim);
        add_beat(KIND_CREATE, dim, any4(), any4());
        if (!gen_owned[dim] && gen_count < MAX_CLOCKS)
        begin
            gen_owned[dim] = 1'b1;
            gen_count++;
        end
    endtask

    task automatic gen_clear();
        add_beat(KIND_CLEAR, any4(), any4(), any4());
        gen_count = 0;
        gen_owned = '0;
    endtask

    task automatic gen_free_create();
        logic [3:0] d;
        d = any4();
        if (gen_owned != 16'hFFFF && $urandom_range(0, 99) < 85)
            while (gen_owned[d])
                d = any4();
        gen_create(d);
    endtask

    task automatic run_sequence();
        int n_new;
        int n_ops;
        int r;
        if ($urandom_range(0, 99) < 80)
            gen_clear();
        n_new = ($urandom_range(0, 3) == 0) ? MAX_CLOCKS + 2 : $urandom_range(1, 8);
        for (int j = 0; j < n_new; j++)
            gen_free_create();
        n_ops = $urandom_range(4, 24);
        for (int j = 0; j < n_ops; j++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                add_beat(KIND_JOIN, any4(), pick_clock(), pick_clock());
            else if (r < 40)
            begin
                // long dependency chain for a deep closure
                for (int i = 0; i + 1 < gen_count; i++)
                    add_beat(KIND_JOIN, any4(), 4'(i), 4'(i + 1));
                add_beat(KIND_SNAPSHOT, any4(), 4'd0, any4());
            end
            else if (r < 65)
                add_beat(KIND_SNAPSHOT, any4(), pick_clock(), any4());
            else if (r < 90)
                add_beat(KIND_TEST, any4(), pick_clock(), any4());
            else if (r < 95)
                add_beat(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
                         any4(), any4(), any4());
            else
                gen_create(any4());
        end
    endtask

    initial
    begin
        wipe_clock_system();
        // directed: empty system, owned dimension, cycles, self and repeated joins,
        // unowned test bit, unknown clocks, spare kinds, clear
        add_beat(KIND_SNAPSHOT, 4'd0, 4'd0, 4'd0);
        add_beat(KIND_JOIN, 4'd0, 4'd0, 4'd0);
        gen_create(4'd15);
        gen_create(4'd15);
        gen_create(4'd0);
        add_beat(KIND_JOIN, 4'd0, 4'd1, 4'd0);
        add_beat(KIND_JOIN, 4'd0, 4'd1, 4'd0);
        add_beat(KIND_JOIN, 4'd0, 4'd0, 4'd0);
        add_beat(KIND_SNAPSHOT, 4'd0, 4'd0, 4'd0);
        add_beat(KIND_JOIN, 4'd0, 4'd0, 4'd1);
        add_beat(KIND_SNAPSHOT, 4'd15, 4'd1, 4'd15);
        add_beat(KIND_TEST, 4'd15, 4'd1, 4'd0);
        add_beat(KIND_TEST, 4'd7, 4'd0, 4'd0);
        add_beat(KIND_TEST, 4'd0, 4'd15, 4'd0);
        add_beat(KIND_JOIN, 4'd0, 4'd0, 4'd15);
        add_beat(KIND_JOIN, 4'd0, 4'd15, 4'd0);
        for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
            add_beat(3'(k), 4'd15, 4'd15, 4'd15);
        gen_clear();
        add_beat(KIND_SNAPSHOT, 4'd0, 4'd0, 4'd0);
        gen_create(4'd0);
        add_beat(KIND_TEST, 4'd0, 4'd0, 4'd0);
        gen_clear();

        while (pending_beats.size() < BEAT_TARGET)
            run_sequence();
        total_beats = pending_beats.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() > 0 || s_tvalid || result_fifo.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d beats in, %0d results checked: create %0d, join %0d, snapshot %0d,",
                 beats_in, results_out, kind_hits[KIND_CREATE], kind_hits[KIND_JOIN],
                 kind_hits[KIND_SNAPSHOT]);
        $display("test %0d, clear %0d; dim-bad %0d, unknown %0d, widest closure %0d clocks",
                 kind_hits[KIND_TEST], kind_hits[KIND_CLEAR], status_hits[STAT_DIM_BAD],
                 status_hits[STAT_UNKNOWN], widest_reach);
        if (errors == 0 && result_fifo.size() == 0)
            $display("dependency_bit_vector_clock_top test passed");
        else
            $display("dependency_bit_vector_clock_top test failed");
        $finish;
    end

endmodule
